FILE: sv/i2c_master_register_transfer_unit_assert.svh
// Assertion macros shared by the checker of the I2C register transfer unit.
`ifndef I2C_MASTER_REGISTER_TRANSFER_UNIT_ASSERT_SVH
`define I2C_MASTER_REGISTER_TRANSFER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("i2cm same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define I2CM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("i2cm next-cycle check failed");

`endif

FILE: sv/i2cm_pkg.sv
`timescale 1ns / 1ps

package i2cm_pkg;

    // Command codes carried by each input item.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Completion codes reported on the last tick of a stop condition.
    localparam logic [1:0] DONE_NONE  = 2'd0;
    localparam logic [1:0] DONE_OK    = 2'd1;
    localparam logic [1:0] DONE_ABORT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_PHASE_TICKS    = 2'd1;
    localparam logic [1:0] CFG_ACK_LIMIT      = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Reset values of the configuration registers.
    localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd80;
    localparam logic [15:0] PHASE_TICKS_RESET    = 16'd10;
    localparam logic [7:0]  ACK_LIMIT_RESET      = 8'd250;

    // Bit of the shifter that is driven onto SDA.
    localparam int MSB_BIT = 7;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [15:0] phase_ticks;
        logic [7:0]  ack_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic [7:0] write_byte;
        logic       sda_sample;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       sda_level;
        logic       write_taken;
        logic [7:0] read_data;
        logic       read_valid;
        logic       read_last;
        logic       busy_res;
        logic [1:0] done_status;
    } out_item_t;

endpackage

FILE: sv/i2cm_cfg_regs.sv
`timescale 1ns / 1ps

module i2cm_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [i2cm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output i2cm_pkg::cfg_t                    cfg
);
    import i2cm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index and merge the written value.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS: cfg_next.device_address = cfg_wdata[6:0];
                CFG_PHASE_TICKS:    cfg_next.phase_ticks    = cfg_wdata[15:0];
                CFG_ACK_LIMIT:      cfg_next.ack_limit      = cfg_wdata[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address <= DEVICE_ADDRESS_RESET;
            cfg_reg.phase_ticks    <= PHASE_TICKS_RESET;
            cfg_reg.ack_limit      <= ACK_LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/i2cm_in_stage.sv
`timescale 1ns / 1ps

module i2cm_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  i2cm_pkg::in_item_t s_item,
    output logic               item_valid,
    input  logic               item_ready,
    output i2cm_pkg::in_item_t item
);
    import i2cm_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // The register takes a new item whenever it is empty or is being drained.
    assign s_ready = !valid_reg || item_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Payload register, loaded on acceptance only.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: sv/i2cm_core.sv
`timescale 1ns / 1ps

module i2cm_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  i2cm_pkg::cfg_t      cfg,
    input  logic                item_valid,
    output logic                item_ready,
    input  i2cm_pkg::in_item_t  item,
    output logic                m_valid,
    input  logic                m_ready,
    output i2cm_pkg::out_item_t result
);
    import i2cm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START_SETUP, PH_START_HOLD, PH_TX_LOW, PH_TX_HIGH,
        PH_ACK_LOW, PH_ACK_HIGH, PH_RX_LOW, PH_RX_HIGH, PH_MACK_LOW,
        PH_MACK_HIGH, PH_RESTART_LOW, PH_STOP_LOW, PH_STOP_HIGH
    } phase_t;

    typedef enum logic [1:0] {
        ST_ADDR, ST_REG, ST_DATA
    } stage_t;

    phase_t      phase_reg, phase_next;
    stage_t      stage_reg, stage_next;
    logic [15:0] pc_reg, pc_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  poll_reg, poll_next;
    logic        read_mode_reg, read_mode_next;
    logic [7:0]  reg_latch_reg, reg_latch_next;
    logic        restart_reg, restart_next;
    logic        aborted_reg, aborted_next;
    logic        out_valid_reg;
    out_item_t   result_reg, result_next;

    logic [15:0] ticks;
    logic        ph_end;
    logic        fire;
    logic [7:0]  rx_byte;

    assign item_ready = !out_valid_reg || m_ready;
    assign fire       = item_valid && item_ready;
    assign ticks      = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;

    // One tick of the bus sequencer: begin check, phase timer, then phase work.
    always_comb begin
        phase_next     = phase_reg;
        stage_next     = stage_reg;
        pc_next        = pc_reg;
        bit_next       = bit_reg;
        left_next      = left_reg;
        shift_next     = shift_reg;
        poll_next      = poll_reg;
        read_mode_next = read_mode_reg;
        reg_latch_next = reg_latch_reg;
        restart_next   = restart_reg;
        aborted_next   = aborted_reg;
        rx_byte        = 8'd0;

        result_next             = '0;
        result_next.scl_level   = 1'b1;
        result_next.sda_drive   = 1'b1;
        result_next.sda_level   = 1'b1;
        result_next.done_status = DONE_NONE;

        // A begin command in idle makes this tick the first start tick.
        if (phase_reg == PH_IDLE && (item.cmd == CMD_WRITE || item.cmd == CMD_READ)) begin
            read_mode_next = (item.cmd == CMD_READ);
            reg_latch_next = item.register_address;
            left_next      = ((item.cmd == CMD_READ) && item.byte_count == 8'd0)
                             ? 8'd1 : item.byte_count;
            restart_next   = 1'b0;
            aborted_next   = 1'b0;
            stage_next     = ST_ADDR;
            shift_next     = {cfg.device_address, 1'b0};
            phase_next     = PH_START_SETUP;
            pc_next        = 16'd0;
        end

        result_next.busy_res = (phase_next != PH_IDLE);
        ph_end = ({1'b0, pc_next} + 17'd1) >= {1'b0, ticks};
        if (!ph_end) begin
            pc_next = pc_next + 16'd1;
        end

        case (phase_next)
            PH_IDLE: begin
            end
            PH_START_SETUP: begin
                if (ph_end) begin
                    phase_next = PH_START_HOLD;
                    pc_next    = 16'd0;
                end
            end
            PH_START_HOLD: begin
                result_next.sda_level = 1'b0;
                if (ph_end) begin
                    bit_next   = 4'd0;
                    phase_next = PH_TX_LOW;
                    pc_next    = 16'd0;
                end
            end
            PH_TX_LOW: begin
                result_next.scl_level = 1'b0;
                result_next.sda_level = shift_next[MSB_BIT];
                if (ph_end) begin
                    phase_next = PH_TX_HIGH;
                    pc_next    = 16'd0;
                end
            end
            PH_TX_HIGH: begin
                result_next.sda_level = shift_next[MSB_BIT];
                if (ph_end) begin
                    shift_next = {shift_next[6:0], 1'b0};
                    bit_next   = bit_next + 4'd1;
                    pc_next    = 16'd0;
                    if (bit_next >= 4'd8) begin
                        poll_next  = 8'd0;
                        phase_next = PH_ACK_LOW;
                    end else begin
                        phase_next = PH_TX_LOW;
                    end
                end
            end
            PH_ACK_LOW: begin
                result_next.scl_level = 1'b0;
                result_next.sda_drive = 1'b0;
                result_next.sda_level = 1'b0;
                if (ph_end) begin
                    phase_next = PH_ACK_HIGH;
                    pc_next    = 16'd0;
                end
            end
            PH_ACK_HIGH: begin
                result_next.sda_drive = 1'b0;
                result_next.sda_level = 1'b0;
                if (!item.sda_sample) begin
                    // Acknowledged: pick the next byte or phase by stage.
                    pc_next = 16'd0;
                    if (stage_next == ST_DATA && left_next != 8'd0) begin
                        left_next = left_next - 8'd1;
                    end
                    if (stage_next == ST_ADDR) begin
                        if (restart_next) begin
                            bit_next   = 4'd0;
                            shift_next = 8'd0;
                            phase_next = PH_RX_LOW;
                        end else begin
                            stage_next = ST_REG;
                            shift_next = reg_latch_next;
                            bit_next   = 4'd0;
                            phase_next = PH_TX_LOW;
                        end
                    end else if (stage_next == ST_REG && read_mode_next) begin
                        phase_next = PH_RESTART_LOW;
                    end else if (left_next != 8'd0) begin
                        stage_next              = ST_DATA;
                        result_next.write_taken = 1'b1;
                        shift_next              = item.write_byte;
                        bit_next                = 4'd0;
                        phase_next              = PH_TX_LOW;
                    end else begin
                        phase_next = PH_STOP_LOW;
                    end
                end else if (poll_next >= cfg.ack_limit) begin
                    aborted_next = 1'b1;
                    phase_next   = PH_STOP_LOW;
                    pc_next      = 16'd0;
                end else begin
                    poll_next = poll_next + 8'd1;
                end
            end
            PH_RESTART_LOW: begin
                result_next.scl_level = 1'b0;
                if (ph_end) begin
                    restart_next = 1'b1;
                    stage_next   = ST_ADDR;
                    shift_next   = {cfg.device_address, 1'b1};
                    phase_next   = PH_START_SETUP;
                    pc_next      = 16'd0;
                end
            end
            PH_RX_LOW: begin
                result_next.scl_level = 1'b0;
                result_next.sda_drive = 1'b0;
                result_next.sda_level = 1'b0;
                if (ph_end) begin
                    phase_next = PH_RX_HIGH;
                    pc_next    = 16'd0;
                end
            end
            PH_RX_HIGH: begin
                result_next.sda_drive = 1'b0;
                result_next.sda_level = 1'b0;
                if (ph_end) begin
                    rx_byte    = {shift_next[6:0], item.sda_sample};
                    shift_next = rx_byte;
                    bit_next   = bit_next + 4'd1;
                    pc_next    = 16'd0;
                    if (bit_next >= 4'd8) begin
                        result_next.read_valid = 1'b1;
                        result_next.read_data  = rx_byte;
                        result_next.read_last  = (left_next <= 8'd1);
                        phase_next             = PH_MACK_LOW;
                    end else begin
                        phase_next = PH_RX_LOW;
                    end
                end
            end
            PH_MACK_LOW: begin
                result_next.scl_level = 1'b0;
                result_next.sda_level = (left_next <= 8'd1);
                if (ph_end) begin
                    phase_next = PH_MACK_HIGH;
                    pc_next    = 16'd0;
                end
            end
            PH_MACK_HIGH: begin
                result_next.sda_level = (left_next <= 8'd1);
                if (ph_end) begin
                    pc_next = 16'd0;
                    if (left_next != 8'd0) begin
                        left_next = left_next - 8'd1;
                    end
                    if (left_next == 8'd0) begin
                        phase_next = PH_STOP_LOW;
                    end else begin
                        bit_next   = 4'd0;
                        shift_next = 8'd0;
                        phase_next = PH_RX_LOW;
                    end
                end
            end
            PH_STOP_LOW: begin
                result_next.scl_level = 1'b0;
                result_next.sda_level = 1'b0;
                if (ph_end) begin
                    phase_next = PH_STOP_HIGH;
                    pc_next    = 16'd0;
                end
            end
            PH_STOP_HIGH: begin
                result_next.sda_level = 1'b0;
                if (ph_end) begin
                    result_next.done_status = aborted_next ? DONE_ABORT : DONE_OK;
                    phase_next              = PH_IDLE;
                    pc_next                 = 16'd0;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                pc_next    = 16'd0;
            end
        endcase
    end

    // Sequencer state and result register advance together on each item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            stage_reg     <= ST_ADDR;
            pc_reg        <= 16'd0;
            bit_reg       <= 4'd0;
            left_reg      <= 8'd0;
            shift_reg     <= 8'd0;
            poll_reg      <= 8'd0;
            read_mode_reg <= 1'b0;
            reg_latch_reg <= 8'd0;
            restart_reg   <= 1'b0;
            aborted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg     <= phase_next;
                stage_reg     <= stage_next;
                pc_reg        <= pc_next;
                bit_reg       <= bit_next;
                left_reg      <= left_next;
                shift_reg     <= shift_next;
                poll_reg      <= poll_next;
                read_mode_reg <= read_mode_next;
                reg_latch_reg <= reg_latch_next;
                restart_reg   <= restart_next;
                aborted_reg   <= aborted_next;
                result_reg    <= result_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign result  = result_reg;

endmodule

FILE: sv/i2c_master_register_transfer_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    cmd, register_address, byte_count,
//                                         write_byte, sda_sample (one tick each)
// m_        out        m_valid/m_ready    SCL/SDA levels, write_taken, read byte,
//                                         busy and completion status
// cfg_      in         cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// Each item passes an input register and a result register.
// One item is accepted per cycle unless m_ready stalls; the sequencer state updates once per item.
// Stalls on m_ready back up through the result register to s_ready.
// aresetn is synchronous and active low; it returns the bus sequencer to idle.

module i2c_master_register_transfer_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_cmd,
    input  logic [7:0]                       s_register_address,
    input  logic [7:0]                       s_byte_count,
    input  logic [7:0]                       s_write_byte,
    input  logic                             s_sda_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_scl_level,
    output logic                             m_sda_drive,
    output logic                             m_sda_level,
    output logic                             m_write_taken,
    output logic [7:0]                       m_read_data,
    output logic                             m_read_valid,
    output logic                             m_read_last,
    output logic                             m_busy_res,
    output logic [1:0]                       m_done_status,
    input  logic                             cfg_wr_en,
    input  logic [i2cm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import i2cm_pkg::*;

    cfg_t      cfg;
    in_item_t  s_item;
    in_item_t  item;
    logic      item_valid;
    logic      item_ready;
    out_item_t result;

    // Gather the input fields into one item.
    assign s_item.cmd              = s_cmd;
    assign s_item.register_address = s_register_address;
    assign s_item.byte_count       = s_byte_count;
    assign s_item.write_byte       = s_write_byte;
    assign s_item.sda_sample       = s_sda_sample;

    i2cm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    i2cm_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    i2cm_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result     (result)
    );

    // Spread the result item onto its ports.
    assign m_scl_level   = result.scl_level;
    assign m_sda_drive   = result.sda_drive;
    assign m_sda_level   = result.sda_level;
    assign m_write_taken = result.write_taken;
    assign m_read_data   = result.read_data;
    assign m_read_valid  = result.read_valid;
    assign m_read_last   = result.read_last;
    assign m_busy_res    = result.busy_res;
    assign m_done_status = result.done_status;

endmodule

FILE: sv/i2cm_checker.sv
`timescale 1ns / 1ps
`include "i2c_master_register_transfer_unit_assert.svh"

module i2cm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_scl_level,
    input logic       m_sda_drive,
    input logic       m_sda_level,
    input logic       m_write_taken,
    input logic [7:0] m_read_data,
    input logic       m_read_valid,
    input logic       m_read_last,
    input logic       m_busy_res,
    input logic [1:0] m_done_status
);
    import i2cm_pkg::*;

    // A stalled result item holds its bus levels and status.
    `I2CM_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_scl_level) && $stable(m_sda_level) && $stable(m_done_status) && $stable(m_read_data))

    // A received byte and a data byte handoff never share a tick.
    `I2CM_ASSERT_NOW(a_rx_tx_excl, aclk, aresetn, m_valid && m_read_valid, !m_write_taken)

    // Completion is reported on the last stop tick: SCL high, SDA driven low.
    `I2CM_ASSERT_NOW(a_done_at_stop, aclk, aresetn, m_valid && (m_done_status != DONE_NONE), m_busy_res && m_scl_level && m_sda_drive && !m_sda_level)

    // An idle bus keeps both lines high and reports nothing.
    `I2CM_ASSERT_NOW(a_idle_bus, aclk, aresetn, m_valid && !m_busy_res, m_scl_level && m_sda_drive && m_sda_level && !m_read_valid && !m_write_taken && (m_done_status == DONE_NONE))

    // The last-byte flag only comes with a received byte.
    `I2CM_ASSERT_NOW(a_last_needs_valid, aclk, aresetn, m_valid && m_read_last, m_read_valid)

endmodule

bind i2c_master_register_transfer_unit i2cm_checker u_i2cm_checker (.*);
